/* hw/rtl/ndpc_pkg.sv */
// ndpc_pkg: shared constants and types for the nearest dark pixel to corners block
// no dependencies; imported by ndpc_best, nearest_dark_pixel_to_corners_top and its testbench

package ndpc_pkg;

    // default frame size limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // field and register widths
    localparam int PIX_W       = 8;
    localparam int DIM_CFG_W   = 13;
    localparam int THR_W       = 8;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int COORD_OUT_W = 12;
    localparam int NUM_CORNERS = 4;
    localparam int OUT_DATA_W  = 2 * NUM_CORNERS * COORD_OUT_W;

    // register reset values
    localparam logic [DIM_CFG_W-1:0] RST_FRAME_WIDTH    = DIM_CFG_W'(640);
    localparam logic [DIM_CFG_W-1:0] RST_FRAME_HEIGHT   = DIM_CFG_W'(480);
    localparam logic [THR_W-1:0]     RST_DARK_THRESHOLD = THR_W'(128);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_DARK_THRESHOLD = 2'd2
    } ndpc_reg_t;

    // control from the commit stage to each corner tracker
    typedef struct packed {
        logic dark_commit;  // a dark pixel is committed this cycle
        logic frame_end;    // the committed pixel closes the frame
    } ndpc_ctl_t;

endpackage

/* hw/rtl/nearest_dark_pixel_to_corners_top.sv */
// nearest_dark_pixel_to_corners_top: raster pixel stream in, per-frame corner result out
// depends on ndpc_pkg and ndpc_best
//
//  channel   direction  ports                          contents
//  pixels    in         s_tvalid s_tready s_tdata      [7:0] pixel
//  result    out        m_tvalid m_tready m_tdata      corner coordinates, m_tuser any_dark
//  config    in         cfg_we cfg_index cfg_wdata     frame_width, frame_height, dark_threshold
//
// one pixel per cycle unless stalled; the result register follows stages 1 and 2
// pipeline: counters and edge offsets, then four squarers, then sum, compare and commit
// the input side stalls only while a frame result waits behind an untaken one
// reset loads register defaults and sets every minimum to infinite; no clearing pass

module nearest_dark_pixel_to_corners_top #(
    parameter int MAX_WIDTH  = ndpc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ndpc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // pixel stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ndpc_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [11:0] top_left_x, [23:12] top_left_y, [35:24] top_right_x, [47:36] top_right_y,
    // [59:48] bottom_left_x, [71:60] bottom_left_y, [83:72] bottom_right_x,
    // [95:84] bottom_right_y
    output logic [ndpc_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tuser,   // [0] any_dark
    // configuration writes
    input  logic                             cfg_we,
    input  logic [ndpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ndpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ndpc_pkg::*;

    // coordinate, offset and distance widths
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int DXW  = $clog2(MAX_WIDTH + 1);
    localparam int DYW  = $clog2(MAX_HEIGHT + 1);
    localparam int SXW  = 2 * DXW;
    localparam int SYW  = 2 * DYW;
    localparam int DW   = ((SXW > SYW) ? SXW : SYW) + 1;
    localparam int CWX  = ((DIM_CFG_W > DXW) ? DIM_CFG_W : DXW) + 1;
    localparam int CWY  = ((DIM_CFG_W > DYW) ? DIM_CFG_W : DYW) + 1;
    localparam int CNX  = ((XW + 1) > DXW) ? (XW + 1) : DXW;
    localparam int CNY  = ((YW + 1) > DYW) ? (YW + 1) : DYW;

    localparam logic [CWX-1:0] MAXW_C = CWX'(MAX_WIDTH);
    localparam logic [CWY-1:0] MAXH_C = CWY'(MAX_HEIGHT);

    // configuration registers
    logic [DIM_CFG_W-1:0] frame_width_reg;
    logic [DIM_CFG_W-1:0] frame_height_reg;
    logic [THR_W-1:0]     dark_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
            dark_threshold_reg <= RST_DARK_THRESHOLD;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_wdata;
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_wdata;
                REG_DARK_THRESHOLD: dark_threshold_reg <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size: zero reads as one, large values saturate
    logic [DXW-1:0] w_eff;
    logic [DYW-1:0] h_eff;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = DXW'(1);
        end else if (CWX'(frame_width_reg) > MAXW_C) begin
            w_eff = DXW'(MAX_WIDTH);
        end else begin
            w_eff = DXW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = DYW'(1);
        end else if (CWY'(frame_height_reg) > MAXH_C) begin
            h_eff = DYW'(MAX_HEIGHT);
        end else begin
            h_eff = DYW'(frame_height_reg);
        end
    end

    // pipeline handshake
    logic p1_valid_reg, p2_valid_reg, p2_last_reg;
    logic m_tvalid_reg;
    logic advance, accept, commit;

    assign advance  = !(p2_valid_reg && p2_last_reg && m_tvalid_reg && !m_tready);
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign commit   = advance && p2_valid_reg;

    // raster counters
    logic [XW-1:0]  col_reg;
    logic [YW-1:0]  row_reg;
    logic [CNX-1:0] col_inc;
    logic [CNY-1:0] row_inc;
    logic           row_wrap, frame_wrap;

    assign col_inc    = CNX'(col_reg) + CNX'(1);
    assign row_inc    = CNY'(row_reg) + CNY'(1);
    assign row_wrap   = col_inc >= CNX'(w_eff);
    assign frame_wrap = row_wrap && (row_inc >= CNY'(h_eff));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (row_wrap) begin
                col_reg <= '0;
                row_reg <= frame_wrap ? '0 : row_inc[YW-1:0];
            end else begin
                col_reg <= col_inc[XW-1:0];
            end
        end
    end

    // offsets to the right and bottom edges
    logic [DXW-1:0] dx_right;
    logic [DYW-1:0] dy_bottom;

    assign dx_right  = (w_eff >= DXW'(col_reg)) ? (w_eff - DXW'(col_reg))
                                                : (DXW'(col_reg) - w_eff);
    assign dy_bottom = (h_eff >= DYW'(row_reg)) ? (h_eff - DYW'(row_reg))
                                                : (DYW'(row_reg) - h_eff);

    // stage 1: classified pixel with its position and edge offsets
    logic           p1_dark_reg, p1_last_reg;
    logic [XW-1:0]  p1_col_reg;
    logic [YW-1:0]  p1_row_reg;
    logic [DXW-1:0] p1_dxr_reg;
    logic [DYW-1:0] p1_dyb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= s_tvalid;
        end
        if (accept) begin
            p1_dark_reg <= s_tdata <= dark_threshold_reg;
            p1_last_reg <= frame_wrap;
            p1_col_reg  <= col_reg;
            p1_row_reg  <= row_reg;
            p1_dxr_reg  <= dx_right;
            p1_dyb_reg  <= dy_bottom;
        end
    end

    // stage 2: squared offsets along each axis
    logic           p2_dark_reg;
    logic [XW-1:0]  p2_col_reg;
    logic [YW-1:0]  p2_row_reg;
    logic [SXW-1:0] sq_xl_reg, sq_xr_reg;
    logic [SYW-1:0] sq_yt_reg, sq_yb_reg;
    logic [DXW-1:0] dx_left;
    logic [DYW-1:0] dy_top;

    assign dx_left = DXW'(p1_col_reg);
    assign dy_top  = DYW'(p1_row_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p2_last_reg  <= 1'b0;
        end else if (advance) begin
            p2_valid_reg <= p1_valid_reg;
            p2_last_reg  <= p1_valid_reg && p1_last_reg;
        end
        if (advance && p1_valid_reg) begin
            p2_dark_reg <= p1_dark_reg;
            p2_col_reg  <= p1_col_reg;
            p2_row_reg  <= p1_row_reg;
            sq_xl_reg   <= SXW'(dx_left) * SXW'(dx_left);
            sq_xr_reg   <= SXW'(p1_dxr_reg) * SXW'(p1_dxr_reg);
            sq_yt_reg   <= SYW'(dy_top) * SYW'(dy_top);
            sq_yb_reg   <= SYW'(p1_dyb_reg) * SYW'(p1_dyb_reg);
        end
    end

    // commit: distances to the four corners and running minima
    ndpc_ctl_t      ctl;
    logic [DW-1:0]  corner_dist [NUM_CORNERS];
    logic [XW-1:0]  pick_col [NUM_CORNERS];
    logic [YW-1:0]  pick_row [NUM_CORNERS];

    assign ctl.dark_commit = commit && p2_dark_reg;
    assign ctl.frame_end   = commit && p2_last_reg;

    assign corner_dist[0] = DW'(sq_xl_reg) + DW'(sq_yt_reg);
    assign corner_dist[1] = DW'(sq_xr_reg) + DW'(sq_yt_reg);
    assign corner_dist[2] = DW'(sq_xl_reg) + DW'(sq_yb_reg);
    assign corner_dist[3] = DW'(sq_xr_reg) + DW'(sq_yb_reg);

    for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
        ndpc_best #(
            .XW (XW),
            .YW (YW),
            .DW (DW)
        ) u_best (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .sq_dist  (corner_dist[k]),
            .col      (p2_col_reg),
            .row      (p2_row_reg),
            .pick_col (pick_col[k]),
            .pick_row (pick_row[k])
        );
    end

    // dark pixel seen in this frame
    logic seen_dark_reg;
    logic seen_dark_now;

    assign seen_dark_now = seen_dark_reg || ctl.dark_commit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_dark_reg <= 1'b0;
        end else if (ctl.frame_end) begin
            seen_dark_reg <= 1'b0;
        end else begin
            seen_dark_reg <= seen_dark_now;
        end
    end

    // result register, loaded by the frame's last transaction
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.frame_end) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (ctl.frame_end) begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
                m_tdata_reg[2*k*COORD_OUT_W +: COORD_OUT_W]     <= COORD_OUT_W'(pick_col[k]);
                m_tdata_reg[(2*k+1)*COORD_OUT_W +: COORD_OUT_W] <= COORD_OUT_W'(pick_row[k]);
            end
            m_tuser_reg <= seen_dark_now;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* hw/rtl/ndpc_best.sv */
// ndpc_best: running strict minimum of squared distance for one reference corner
// depends on ndpc_pkg for the control struct

module ndpc_best #(
    parameter int XW = 12,
    parameter int YW = 12,
    parameter int DW = 27
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ndpc_pkg::ndpc_ctl_t  ctl,
    input  logic [DW-1:0]        sq_dist,
    input  logic [XW-1:0]        col,
    input  logic [YW-1:0]        row,
    output logic [XW-1:0]        pick_col,
    output logic [YW-1:0]        pick_row
);
    import ndpc_pkg::*;

    logic [DW-1:0] best_dist_reg, best_dist_next;
    logic [XW-1:0] best_col_reg, best_col_next;
    logic [YW-1:0] best_row_reg, best_row_next;
    logic          take;

    // strict less-than keeps the earliest pixel on a tie
    assign take = ctl.dark_commit && (sq_dist < best_dist_reg);

    // winner including the pixel committed this cycle
    assign pick_col = take ? col : best_col_reg;
    assign pick_row = take ? row : best_row_reg;

    // clear at frame end, otherwise track the minimum
    always_comb begin
        best_dist_next = best_dist_reg;
        best_col_next  = best_col_reg;
        best_row_next  = best_row_reg;
        if (ctl.frame_end) begin
            best_dist_next = '1;
            best_col_next  = '0;
            best_row_next  = '0;
        end else if (take) begin
            best_dist_next = sq_dist;
            best_col_next  = col;
            best_row_next  = row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_dist_reg <= '1;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
        end else begin
            best_dist_reg <= best_dist_next;
            best_col_reg  <= best_col_next;
            best_row_reg  <= best_row_next;
        end
    end

endmodule

/* tb/sv/nearest_dark_pixel_to_corners_top_tb.sv */
// nearest_dark_pixel_to_corners_top_tb: self-checking bench for the dark pixel corner tracker
// streams raster pixels with random gaps and stalls, predicts each frame result and compares
// depends on ndpc_pkg and nearest_dark_pixel_to_corners_top

module nearest_dark_pixel_to_corners_top_tb;
    import ndpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W          = DEF_MAX_WIDTH;
    localparam int MAX_H          = DEF_MAX_HEIGHT;
    localparam int DIST_W         = 26;
    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PIXELS  = 800;
    localparam int RANDOM_FRAMES  = 16;
    localparam int EXT_RUN        = 24;
    localparam int JUNK_W         = CFG_DATA_W - THR_W;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [NUM_CORNERS-1:0][COORD_OUT_W-1:0] col;
        logic [NUM_CORNERS-1:0][COORD_OUT_W-1:0] row;
        logic                                    any_dark;
    } corner_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // predictor copy of registers and frame state
    logic [DIM_CFG_W-1:0]   model_width  = RST_FRAME_WIDTH;
    logic [DIM_CFG_W-1:0]   model_height = RST_FRAME_HEIGHT;
    logic [THR_W-1:0]       model_thr    = RST_DARK_THRESHOLD;
    logic [COORD_OUT_W-1:0] col_cnt;
    logic [COORD_OUT_W-1:0] row_cnt;
    logic [DIST_W-1:0]      best_dist [NUM_CORNERS];
    logic [COORD_OUT_W-1:0] best_col  [NUM_CORNERS];
    logic [COORD_OUT_W-1:0] best_row  [NUM_CORNERS];
    logic                   seen_dark;

    logic [PIX_W-1:0]       pixel_q [$];
    corner_result_t         frame_result_q [$];
    int                     pixels_outstanding = 0;
    int                     pixels_taken       = 0;
    int                     frames_checked     = 0;
    int                     setting_count      = 0;
    int                     error_count        = 0;
    int                     idle_cycles        = 0;
    int                     drv_quiet          = 0;
    int                     mon_quiet          = 0;
    string                  corner_name [NUM_CORNERS] =
        '{"top_left", "top_right", "bottom_left", "bottom_right"};

    nearest_dark_pixel_to_corners_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // zero means one, anything past the parameter saturates
    function automatic int eff_dim(input logic [DIM_CFG_W-1:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // mostly short pauses, a few long ones, now and then a long quiet stretch
    function automatic int pick_pause(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 3) begin
            quiet = $urandom_range(50, 400);
            return 0;
        end
        if (r < 600) return 0;
        if (r < 950) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic clear_tracking();
        col_cnt   = '0;
        row_cnt   = '0;
        seen_dark = 1'b0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            best_dist[k] = '1;
            best_col[k]  = '0;
            best_row[k]  = '0;
        end
    endtask

    // running minima per corner, one accepted pixel at a time
    task automatic track_pixel(input logic [PIX_W-1:0] pix);
        int w, h, x, y, dx, dy, nx, ny;
        logic [DIST_W-1:0] sq_dist;
        corner_result_t res;
        w = eff_dim(model_width, MAX_W);
        h = eff_dim(model_height, MAX_H);
        x = col_cnt;
        y = row_cnt;
        if (pix <= model_thr) begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
                // odd corners sit on the right edge, corners 2 and 3 on the bottom edge
                dx = (k % 2 == 1) ? ((w >= x) ? w - x : x - w) : x;
                dy = (k >= 2) ? ((h >= y) ? h - y : y - h) : y;
                sq_dist = DIST_W'(dx * dx + dy * dy);
                if (sq_dist < best_dist[k]) begin
                    best_dist[k] = sq_dist;
                    best_col[k]  = x[COORD_OUT_W-1:0];
                    best_row[k]  = y[COORD_OUT_W-1:0];
                end
            end
            seen_dark = 1'b1;
        end
        nx = x + 1;
        if (nx >= w) begin
            col_cnt = '0;
            ny = y + 1;
            if (ny >= h) begin
                for (int k = 0; k < NUM_CORNERS; k++) begin
                    res.col[k] = best_col[k];
                    res.row[k] = best_row[k];
                end
                res.any_dark = seen_dark;
                frame_result_q.push_back(res);
                clear_tracking();
            end else begin
                row_cnt = ny[COORD_OUT_W-1:0];
            end
        end else begin
            col_cnt = nx[COORD_OUT_W-1:0];
        end
    endtask

    // single register write, block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:    model_width  = val;
            REG_FRAME_HEIGHT:   model_height = val;
            REG_DARK_THRESHOLD: model_thr    = val[THR_W-1:0];
            default: ;
        endcase
    endtask

    // threshold write carries junk in the unused upper bits
    task automatic set_frame(input int w, input int h, input int thr);
        logic [JUNK_W-1:0] junk;
        junk = JUNK_W'($urandom_range(0, 31));
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_DARK_THRESHOLD, {junk, thr[THR_W-1:0]});
        setting_count++;
    endtask

    // pixels around the current threshold, dark share set by dark_pct
    task automatic push_pixels(input int n, input int dark_pct);
        logic [PIX_W-1:0] pix;
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 10) pix = PIX_W'($urandom_range(0, 255));
            else if (r < 20) pix = PIX_W'(model_thr + $urandom_range(0, 1));
            else if ($urandom_range(0, 99) < dark_pct) pix = PIX_W'($urandom_range(0, model_thr));
            else if (model_thr == '1) pix = '1;
            else pix = PIX_W'($urandom_range(model_thr + 1, 255));
            pixel_q.push_back(pix);
            pixels_outstanding++;
        end
    endtask

    // pixels needed to close the frame from the current counters and sizes
    task automatic finish_frame(input int dark_pct, output int n);
        int w, h;
        w = eff_dim(model_width, MAX_W);
        h = eff_dim(model_height, MAX_H);
        n = (col_cnt + 1 >= w) ? 1 : w - col_cnt;
        if (row_cnt + 1 < h) n += (h - row_cnt - 1) * w;
        push_pixels(n, dark_pct);
    endtask

    // all pixels taken, all results seen, pipeline drained
    task automatic wait_idle();
        do @(posedge aclk);
        while (pixels_outstanding != 0 || frame_result_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // pixel driver: holds the transaction until taken, random gaps between pixels
    always @(posedge aclk) begin : pixel_driver
        int gap_left;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_pixel(s_tdata);
                pixels_taken++;
                pixels_outstanding--;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_tdata  <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left = pick_pause(drv_quiet);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: field-by-field compare against the oldest predicted frame
    always @(posedge aclk) begin : result_monitor
        int stall_left;
        corner_result_t want;
        logic [COORD_OUT_W-1:0] got_col, got_row;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (frame_result_q.size() == 0) begin
                    $display("%0t: result with no frame pending, actual m_tdata=%h m_tuser=%b",
                             $time, m_tdata, m_tuser);
                    error_count++;
                end else begin
                    want = frame_result_q.pop_front();
                    frames_checked++;
                    for (int k = 0; k < NUM_CORNERS; k++) begin
                        got_col = m_tdata[k*2*COORD_OUT_W +: COORD_OUT_W];
                        got_row = m_tdata[k*2*COORD_OUT_W+COORD_OUT_W +: COORD_OUT_W];
                        if (got_col !== want.col[k]) begin
                            $display("%0t: %s_x expected %0d actual %0d",
                                     $time, corner_name[k], want.col[k], got_col);
                            error_count++;
                        end
                        if (got_row !== want.row[k]) begin
                            $display("%0t: %s_y expected %0d actual %0d",
                                     $time, corner_name[k], want.row[k], got_row);
                            error_count++;
                        end
                    end
                    if (m_tuser !== want.any_dark) begin
                        $display("%0t: any_dark expected %b actual %b",
                                 $time, want.any_dark, m_tuser);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_pause(mon_quiet);
                m_tready <= (stall_left == 0);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("nearest_dark_pixel_to_corners_top_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int w, h, thr, dark_pct, frames, n, k, sel;
        int random_pixels, random_frames;
        int ext_w [4];
        int ext_h [4];
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] val;
        ext_w = '{8191, 4096, 1, 0};
        ext_h = '{1, 2, 4096, 8191};
        random_pixels = 0;
        random_frames = 0;
        clear_tracking();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset sizes and threshold, then shrink the frame in the middle of row 0
        pixel_q.push_back(8'd0);
        pixel_q.push_back(8'd255);
        pixel_q.push_back(8'd128);
        pixel_q.push_back(8'd129);
        pixels_outstanding += 4;
        push_pixels(16, 50);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(5));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 8191)));
        setting_count++;
        finish_frame(50, n);
        wait_idle();

        // frame with no dark pixel
        set_frame(2, 1, 0);
        pixel_q.push_back(8'd255);
        pixel_q.push_back(8'd1);
        pixels_outstanding += 2;
        wait_idle();

        // zero sizes act as one, brightest value dark at full threshold
        set_frame(0, 0, 255);
        pixel_q.push_back(8'd255);
        pixels_outstanding++;
        wait_idle();

        // random small frames, some with a register change mid-frame
        while (random_pixels < RANDOM_PIXELS || random_frames < RANDOM_FRAMES) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            h = $urandom_range(0, 8);
            case ($urandom_range(0, 7))
                0:       thr = 0;
                1:       thr = 255;
                default: thr = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 4))
                0:       dark_pct = 0;
                1:       dark_pct = 3;
                2:       dark_pct = 25;
                3:       dark_pct = 60;
                default: dark_pct = 100;
            endcase
            frames = $urandom_range(1, 4);
            set_frame(w, h, thr);
            n = eff_dim(model_width, MAX_W) * eff_dim(model_height, MAX_H);
            push_pixels(frames * n, dark_pct);
            random_pixels += frames * n;
            random_frames += frames;
            if (n >= 2 && $urandom_range(0, 3) == 0) begin
                k = $urandom_range(1, n - 1);
                push_pixels(k, dark_pct);
                random_pixels += k;
                wait_idle();
                sel = $urandom_range(0, 3);
                idx = CFG_IDX_W'(sel);
                case (idx)
                    REG_FRAME_WIDTH, REG_FRAME_HEIGHT: val = CFG_DATA_W'($urandom_range(0, 12));
                    REG_DARK_THRESHOLD:                val = CFG_DATA_W'($urandom_range(0, 255));
                    default:                           val = CFG_DATA_W'($urandom_range(0, 8191));
                endcase
                write_reg(idx, val);
                setting_count++;
                finish_frame(dark_pct, n);
                random_pixels += n;
                random_frames++;
            end
            wait_idle();
        end

        // largest, saturated and zero sizes, a short run and then a shrink that closes the frame
        for (int e = 0; e < 4; e++) begin
            set_frame(ext_w[e], ext_h[e], $urandom_range(0, 255));
            push_pixels(EXT_RUN, $urandom_range(20, 80));
            wait_idle();
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(5));
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
            setting_count++;
            finish_frame(50, n);
            wait_idle();
        end

        $display("covered %0d pixels and %0d frame results over %0d register settings,",
                 pixels_taken, frames_checked, setting_count);
        $display("including zero and saturated sizes and mid-frame writes");
        if (error_count == 0) begin
            $display("nearest_dark_pixel_to_corners_top_tb OK");
        end else begin
            $display("nearest_dark_pixel_to_corners_top_tb NOT OK");
        end
        $finish;
    end

endmodule

/* nearest_dark_pixel_to_corners_top.f */
hw/rtl/ndpc_pkg.sv
hw/rtl/ndpc_best.sv
hw/rtl/nearest_dark_pixel_to_corners_top.sv
tb/sv/nearest_dark_pixel_to_corners_top_tb.sv
